FILE: design/ilm_pkg.sv
package ilm_pkg;

    // Sizes of the stores and of the lane array
    localparam int MAX_IN       = 4096;
    localparam int TABLE_LEVELS = 16;
    localparam int LANES        = 8;

    localparam int LANE_SEL_W = $clog2(LANES);
    localparam int VEC_ROWS   = MAX_IN / LANES;
    localparam int VADDR_W    = (VEC_ROWS > 1) ? $clog2(VEC_ROWS) : 1;
    localparam int LVL_W      = $clog2(TABLE_LEVELS);
    localparam int CODE_W     = 4;
    localparam int HALF_LANES = LANES / 2;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int INDEX_W    = 12;
    localparam int VALUE_W    = 16;
    localparam int PACKED_W   = 32;
    localparam int SUM_W      = 48;
    localparam int ROW_W      = 16;
    localparam int LEN_W      = 13;
    localparam int WC_W       = LEN_W - LANE_SEL_W;
    localparam int PROD_W     = 2 * VALUE_W;
    localparam int QUAD_W     = PROD_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Commands
    localparam logic [CMD_W-1:0] CMD_VECTOR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LEVEL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WEIGHTS = 2'd2;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_IN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;
    localparam logic [LEN_W-1:0]     IN_LENGTH_RST = 13'd8;
    localparam logic [ROW_W-1:0]     ROW_COUNT_RST = 16'd1;

    typedef struct packed {
        logic                      vec_we;
        logic                      lvl_we;
        logic [VADDR_W-1:0]        vec_waddr;
        logic [LVL_W-1:0]          lvl_waddr;
        logic signed [VALUE_W-1:0] wdata;
        logic [VADDR_W-1:0]        vec_raddr;
        logic [CODE_W-1:0]         code;
    } lane_ctl_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [ROW_W-1:0] row;
    } stage_meta_t;

endpackage

FILE: design/ilm_ifs.sv
interface ilm_item_if import ilm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [INDEX_W-1:0]         index;
    logic signed [VALUE_W-1:0]  value;
    logic [PACKED_W-1:0]        packed_weights;

    modport source (output valid, cmd, index, value, packed_weights, input ready);
    modport sink   (input valid, cmd, index, value, packed_weights, output ready);
endinterface

interface ilm_result_if import ilm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [SUM_W-1:0]  row_sum;
    logic [ROW_W-1:0]         row_index;

    modport source (output valid, row_sum, row_index, input ready);
    modport sink   (input valid, row_sum, row_index, output ready);
endinterface

interface ilm_cfg_if import ilm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/int4_lut_matvec.sv
// int4_lut_matvec: matrix-vector product with 4-bit weight codes and a level table.
// Channels: items (sink) carries cmd, index, value and packed_weights; results
// (source) carries row_sum and row_index; cfg (sink) writes in_length (index 0)
// and row_count (index 1) and is always ready. All move one transaction per
// rising clk edge where valid and ready are high.
// A vector element transaction writes one entry of one lane's vector slice; a
// level transaction writes the level into the table copy of all eight lanes.
// Each weight transaction feeds eight lanes at once; one item per cycle is taken
// while items is ready. The row sum shows on results once the last weight word
// of the row has passed lane memory read, multiply, quad sums, then accumulate
// into the output register. Loads take effect for a word taken the next cycle.
// Stall: while a row sum waits on results, the whole pipeline holds and items
// is not ready; otherwise items stays ready even with a result presented.
// Reset (rst_n low, asynchronous) clears the accumulator, word and row
// counters, the pipeline valid flags and restores in_length 8 and row_count 1.
// The vector and level stores are not cleared; no clearing pass is run.
module int4_lut_matvec import ilm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ilm_item_if.sink     items,
    ilm_cfg_if.sink      cfg,
    ilm_result_if.source results
);

    logic [LEN_W-1:0]   in_length_reg;
    logic [ROW_W-1:0]   row_count_reg;
    logic [WC_W-1:0]    wc_reg;
    logic [WC_W-1:0]    wc_next;
    logic [ROW_W-1:0]   rc_reg;
    logic [ROW_W-1:0]   rc_next;
    stage_meta_t        s0_reg;
    stage_meta_t        s1_reg;

    logic               advance;
    logic               item_accept;
    logic               word_accept;
    logic [WC_W:0]      words;
    logic [WC_W:0]      wc_inc;
    logic               row_last;
    logic [ROW_W-1:0]   rows;
    logic [ROW_W:0]     rc_inc;

    logic signed [PROD_W-1:0] products [LANES];

    // Configuration: always accepted; the user must write it only while idle, the block does not enforce this
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_length_reg <= IN_LENGTH_RST;
            row_count_reg <= ROW_COUNT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_IN_LENGTH: in_length_reg <= cfg.data[LEN_W-1:0];
                REG_ROW_COUNT: row_count_reg <= cfg.data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    assign items.ready = advance;
    assign item_accept = items.valid && advance;
    assign word_accept = item_accept && (items.cmd == CMD_WEIGHTS);

    // Words per row from the length, with a short length counting as one word
    always_comb
    begin
        words = {1'b0, in_length_reg[LEN_W-1:LANE_SEL_W]};
        if (words == '0)
        begin
            words = (WC_W+1)'(1);
        end
        wc_inc   = {1'b0, wc_reg} + (WC_W+1)'(1);
        row_last = wc_inc >= words;
        rows     = (row_count_reg == '0) ? ROW_W'(1) : row_count_reg;
        rc_inc   = {1'b0, rc_reg} + (ROW_W+1)'(1);
        wc_next  = wc_reg;
        rc_next  = rc_reg;
        if (word_accept)
        begin
            if (row_last)
            begin
                wc_next = '0;
                rc_next = (rc_inc >= {1'b0, rows}) ? '0 : rc_inc[ROW_W-1:0];
            end
            else
            begin
                wc_next = wc_inc[WC_W-1:0];
            end
        end
    end

    // Advance the row bookkeeping alongside the lane read and multiply stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg <= '0;
            rc_reg <= '0;
            s0_reg <= '0;
            s1_reg <= '0;
        end
        else
        begin
            wc_reg <= wc_next;
            rc_reg <= rc_next;
            if (advance)
            begin
                s0_reg.valid <= word_accept;
                s0_reg.last  <= row_last;
                s0_reg.row   <= rc_reg;
                s1_reg       <= s0_reg;
            end
        end
    end

    // Lane l takes element 8w+l: low nibbles feed the first half, high nibbles the second
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        lane_ctl_t ctl;

        always_comb
        begin
            ctl.vec_we    = item_accept && (items.cmd == CMD_VECTOR)
                            && (32'(items.index) < MAX_IN)
                            && (items.index[LANE_SEL_W-1:0] == LANE_SEL_W'(l));
            ctl.lvl_we    = item_accept && (items.cmd == CMD_LEVEL)
                            && (32'(items.index) < TABLE_LEVELS);
            ctl.vec_waddr = VADDR_W'(items.index >> LANE_SEL_W);
            ctl.lvl_waddr = items.index[LVL_W-1:0];
            ctl.wdata     = items.value;
            ctl.vec_raddr = VADDR_W'(wc_reg);
            if (l < HALF_LANES)
            begin
                ctl.code = items.packed_weights[8 * l +: CODE_W];
            end
            else
            begin
                ctl.code = items.packed_weights[8 * (l - HALF_LANES) + CODE_W +: CODE_W];
            end
        end

        ilm_lane u_lane
        (
            .clk     (clk),
            .en      (advance),
            .ctl     (ctl),
            .product (products[l])
        );
    end

    ilm_merge u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1       (s1_reg),
        .products (products),
        .advance  (advance),
        .results  (results)
    );

    a_load_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && (items.cmd != CMD_WEIGHTS) |=> !s0_reg.valid)
        else $error("load transaction entered the product pipeline");

    a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
        word_accept && row_last |=> wc_reg == '0)
        else $error("word count not restarted at row end");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(s0_reg))
        else $error("pipeline moved during output stall");

endmodule

FILE: design/ilm_lane.sv
// One lane: its slice of the vector, its own copy of the level table, one multiplier.
module ilm_lane import ilm_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  lane_ctl_t                 ctl,
    output logic signed [PROD_W-1:0]  product
);

    logic signed [VALUE_W-1:0] vec_mem [VEC_ROWS];
    logic signed [VALUE_W-1:0] lvl_mem [TABLE_LEVELS];

    logic signed [VALUE_W-1:0] x_reg;
    logic signed [VALUE_W-1:0] lvl_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.vec_we)
        begin
            vec_mem[ctl.vec_waddr] <= ctl.wdata;
        end
        if (ctl.lvl_we)
        begin
            lvl_mem[ctl.lvl_waddr] <= ctl.wdata;
        end
        if (en)
        begin
            x_reg    <= vec_mem[ctl.vec_raddr];
            lvl_reg  <= lvl_mem[ctl.code];
            prod_reg <= PROD_W'(x_reg) * PROD_W'(lvl_reg);
        end
    end

    assign product = prod_reg;

endmodule

FILE: design/ilm_merge.sv
// Merge the lane products: two quad sums, then accumulate and present the row sum.
module ilm_merge import ilm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  stage_meta_t               s1,
    input  logic signed [PROD_W-1:0]  products [LANES],
    output logic                      advance,
    ilm_result_if.source              results
);

    stage_meta_t               s2_reg;
    logic signed [QUAD_W-1:0]  quad_reg  [2];
    logic signed [QUAD_W-1:0]  quad_next [2];
    logic signed [SUM_W-1:0]   acc_reg;
    logic signed [SUM_W-1:0]   acc_next;
    logic signed [SUM_W-1:0]   total;
    logic signed [SUM_W-1:0]   row_sum_reg;
    logic signed [SUM_W-1:0]   row_sum_next;
    logic [ROW_W-1:0]          row_index_reg;
    logic [ROW_W-1:0]          row_index_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;

    // Whole pipeline moves unless a finished row sum is stuck at the output
    assign advance = !out_valid_reg || results.ready;

    always_comb
    begin
        for (int h = 0; h < 2; h++)
        begin
            quad_next[h] = '0;
            for (int k = 0; k < HALF_LANES; k++)
            begin
                quad_next[h] = quad_next[h] + QUAD_W'(products[h * HALF_LANES + k]);
            end
        end
    end

    always_comb
    begin
        total          = acc_reg + SUM_W'(quad_reg[0]) + SUM_W'(quad_reg[1]);
        acc_next       = acc_reg;
        row_sum_next   = row_sum_reg;
        row_index_next = row_index_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s2_reg.valid && s2_reg.last;
            if (s2_reg.valid)
            begin
                if (s2_reg.last)
                begin
                    acc_next       = '0;
                    row_sum_next   = total;
                    row_index_next = s2_reg.row;
                end
                else
                begin
                    acc_next = total;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg        <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s2_reg <= s1;
            end
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            quad_reg[0] <= quad_next[0];
            quad_reg[1] <= quad_next[1];
        end
        row_sum_reg   <= row_sum_next;
        row_index_reg <= row_index_next;
    end

    assign results.valid     = out_valid_reg;
    assign results.row_sum   = row_sum_reg;
    assign results.row_index = row_index_reg;

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s2_reg.valid && s2_reg.last |=> acc_reg == '0)
        else $error("accumulator not cleared after row end");

    a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(acc_reg))
        else $error("accumulator moved during output stall");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |=> out_valid_reg && $stable(row_sum_reg)
        && $stable(row_index_reg))
        else $error("row sum changed while waiting on results");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top import ilm_pkg::*; ();

    // The block has no code for the fourth command value; it must be ignored
    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;

    // Three stages behind the last word of a row, then the output register;
    // leave a comfortable margin before touching the registers
    localparam int DRAIN_CYCLES     = 12;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int PHASE_ITEMS      = 108;
    localparam int RANDOM_PHASES    = 8;
    localparam int PRESSURE_PHASE   = 2;
    localparam int UNUSED_REG_PHASE = 4;
    localparam int FIRST_WORDS      = 10;
    // Rows never reach past this many vector elements, all of them loaded first
    localparam int VEC_USED         = 64;
    localparam int CYCLE_LIMIT      = 1000000;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
        logic [PACKED_W-1:0]       packed_weights;
    } item_t;

    typedef struct packed {
        logic [SUM_W-1:0] row_sum;
        logic [ROW_W-1:0] row_index;
    } row_result_t;

    // Tracks the vector store, the level table, the running row sum and the
    // row counter, and keeps the row sums still owed by the block in order.
    class row_sum_tracker;
        logic signed [VALUE_W-1:0] vector_mem [MAX_IN];
        logic signed [VALUE_W-1:0] level_mem [TABLE_LEVELS];
        logic [SUM_W-1:0]          acc;
        int unsigned               word_pos;
        int unsigned               row_now;
        int unsigned               len_reg;
        int unsigned               rows_reg;
        row_result_t               pending_sums[$];
        int                        mismatches;
        int                        items_taken;
        int                        rows_checked;

        function new();
            acc          = '0;
            word_pos     = 0;
            row_now      = 0;
            len_reg      = 32'(IN_LENGTH_RST);
            rows_reg     = 32'(ROW_COUNT_RST);
            mismatches   = 0;
            items_taken  = 0;
            rows_checked = 0;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_IN_LENGTH)
                len_reg = 32'(data[LEN_W-1:0]);
            else if (idx == REG_ROW_COUNT)
                rows_reg = 32'(data);
        endfunction

        function void add_word(logic [PACKED_W-1:0] w);
            logic [7:0]                b8;
            logic [INDEX_W-1:0]        lo_a;
            logic [INDEX_W-1:0]        hi_a;
            logic signed [PROD_W-1:0]  lo_p;
            logic signed [PROD_W-1:0]  hi_p;
            int unsigned               base;
            int unsigned               words;
            int unsigned               limit;
            row_result_t               r;
            base = word_pos * LANES;
            // low nibble of byte k pairs with element base+k, high nibble with base+4+k
            for (int k = 0; k < HALF_LANES; k++)
            begin
                b8   = w[8*k +: 8];
                lo_a = INDEX_W'(base + k);
                hi_a = INDEX_W'(base + HALF_LANES + k);
                lo_p = PROD_W'(level_mem[b8[3:0]]) * PROD_W'(vector_mem[lo_a]);
                hi_p = PROD_W'(level_mem[b8[7:4]]) * PROD_W'(vector_mem[hi_a]);
                acc  = acc + {{(SUM_W-PROD_W){lo_p[PROD_W-1]}}, lo_p}
                           + {{(SUM_W-PROD_W){hi_p[PROD_W-1]}}, hi_p};
            end
            words = len_reg / LANES;
            if (words == 0)
                words = 1;
            limit = (rows_reg == 0) ? 1 : rows_reg;
            if (word_pos + 1 >= words)
            begin
                r.row_sum   = acc;
                r.row_index = row_now[ROW_W-1:0];
                pending_sums.push_back(r);
                acc      = '0;
                word_pos = 0;
                row_now  = row_now + 1;
                if (row_now >= limit)
                    row_now = 0;
            end
            else
            begin
                word_pos = (word_pos + 1) & ((1 << WC_W) - 1);
            end
        endfunction

        function void take_item(item_t it);
            case (it.cmd)
                CMD_VECTOR:  vector_mem[it.index] = it.value;
                CMD_LEVEL:
                    if (it.index < TABLE_LEVELS)
                        level_mem[it.index[LVL_W-1:0]] = it.value;
                CMD_WEIGHTS: add_word(it.packed_weights);
                default:     ;
            endcase
            items_taken++;
        endfunction

        task check_row(logic [SUM_W-1:0] got_sum, logic [ROW_W-1:0] got_row);
            row_result_t want;
            if (pending_sums.size() == 0)
            begin
                report($sformatf("row sum %0d for row %0d with nothing owed",
                                 $signed(got_sum), got_row));
                return;
            end
            want = pending_sums.pop_front();
            rows_checked++;
            if (got_sum !== want.row_sum)
                report($sformatf("row %0d: sum %0d, want %0d", want.row_index,
                                 $signed(got_sum), $signed(want.row_sum)));
            if (got_row !== want.row_index)
                report($sformatf("row index %0d, want %0d", got_row, want.row_index));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   hold_requests = 0;

    row_sum_tracker sb = new();

    ilm_item_if   item_ch ();
    ilm_cfg_if    cfg_ch ();
    ilm_result_if res_ch ();

    int4_lut_matvec u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .cfg     (cfg_ch),
        .results (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return int'($urandom_range(20, 80));
        return int'($urandom_range(0, 3));
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return {1'b1, {(VALUE_W-1){1'b0}}};
        if (pick == 1)
            return {1'b0, {(VALUE_W-1){1'b1}}};
        return VALUE_W'($urandom);
    endfunction

    function automatic item_t make_item(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] index,
                                        logic signed [VALUE_W-1:0] value,
                                        logic [PACKED_W-1:0] w);
        item_t it;
        it.cmd            = cmd;
        it.index          = index;
        it.value          = value;
        it.packed_weights = w;
        return it;
    endfunction

    // Mostly weight words, with loads, out-of-table levels and the unused command mixed in
    function automatic item_t rand_item();
        item_t       it;
        int unsigned pick;
        pick              = $urandom_range(0, 99);
        it.cmd            = CMD_WEIGHTS;
        it.index          = INDEX_W'($urandom);
        it.value          = rand_value();
        it.packed_weights = $urandom;
        if (pick < 8)
        begin
            it.cmd   = CMD_VECTOR;
            it.index = (pick < 2) ? INDEX_W'($urandom)
                                  : INDEX_W'($urandom_range(0, VEC_USED - 1));
        end
        else if (pick < 16)
        begin
            it.cmd   = CMD_LEVEL;
            it.index = INDEX_W'($urandom_range(0, 2 * TABLE_LEVELS - 1));
        end
        else if (pick < 19)
        begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] phase_length(int p);
        case (p)
            0:       return 16'd64;
            1:       return 16'd16;
            2:       return 16'd8;
            3:       return 16'd3;
            4:       return 16'd21;
            5:       return 16'd71;
            6:       return 16'd0;
            default: return 16'd40;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] phase_rows(int p);
        case (p)
            0:       return 16'd3;
            1:       return 16'd0;
            2:       return 16'd5;
            3:       return 16'd65535;
            4:       return 16'd4;
            5:       return 16'd2;
            6:       return 16'd1;
            default: return 16'd7;
        endcase
    endfunction

    // Offer one transaction and hold it until taken, then idle for a random gap, which may be empty
    task automatic send_item(input item_t it);
        int gap;
        item_ch.valid          <= 1'b1;
        item_ch.cmd            <= it.cmd;
        item_ch.index          <= it.index;
        item_ch.value          <= it.value;
        item_ch.packed_weights <= it.packed_weights;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.take_item(it);
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.set_reg(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and hold until every owed row sum is back and the pipeline is empty
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_sums.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : sender
        rst_n                  <= 1'b0;
        item_ch.valid          <= 1'b0;
        item_ch.cmd            <= CMD_VECTOR;
        item_ch.index          <= '0;
        item_ch.value          <= '0;
        item_ch.packed_weights <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= REG_IN_LENGTH;
        cfg_ch.data            <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < TABLE_LEVELS; i++)
            send_item(make_item(CMD_LEVEL, INDEX_W'(i), rand_value(), '0));
        for (int i = 0; i < VEC_USED; i++)
            send_item(make_item(CMD_VECTOR, INDEX_W'(i), rand_value(), '0));

        // A few rows under the reset register values
        for (int i = 0; i < FIRST_WORDS; i++)
            send_item(make_item(CMD_WEIGHTS, '0, '0, $urandom));

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            write_cfg(REG_IN_LENGTH, phase_length(p));
            write_cfg(REG_ROW_COUNT, phase_rows(p));
            if (p == UNUSED_REG_PHASE)
                write_cfg(REG_UNUSED, CFG_DATA_W'($urandom));
            if (p == PRESSURE_PHASE)
                hold_requests++;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(rand_item());
        end

        wait_idle();
        $display("tb_top: %0d transactions taken, %0d row sums checked over %0d settings",
                 sb.items_taken, sb.rows_checked, RANDOM_PHASES + 1);
        $display("tb_top: short and odd lengths, zero row count, loads mid-row, %0d-cycle stall",
                 HOLD_OFF_CYCLES);
        if (sb.mismatches == 0 && sb.pending_sums.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Receiver: random ready with gaps, plus one long hold-off counted here
    initial
    begin : receiver
        int stall_left;
        int hold_served;
        stall_left   = 0;
        hold_served  = 0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                sb.check_row(res_ch.row_sum, res_ch.row_index);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                stall_left  = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < 20)
            begin
                res_ch.ready <= 1'b0;
                stall_left = pick_gap();
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                sb.report("cycle limit reached");
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

endmodule
